### hw/rtl/pdta_pkg.sv
`default_nettype none
package pdta_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int SLOT_W = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [2:0] EV_BADSYNC = 3'd0;
	localparam logic [2:0] EV_OFFNET  = 3'd1;
	localparam logic [2:0] EV_ADDED   = 3'd2;
	localparam logic [2:0] EV_REFRESH = 3'd3;
	localparam logic [2:0] EV_BEACON  = 3'd4;
	localparam logic [2:0] EV_FULL    = 3'd5;
	localparam logic [2:0] EV_DOWN    = 3'd6;
	localparam logic [2:0] EV_DONE    = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_INST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIFETIME  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_CTRL = 3'd5;

	typedef struct packed {
		logic [63:0] uid;
		logic [31:0] ip;
		logic [7:0]  prio;
		logic        ctype;
		logic [47:0] seen;
	} ent_t;

	typedef struct packed {
		logic [31:0] own_ip;
		logic [31:0] mask;
		logic [31:0] sync;
		logic [15:0] ctrl_inst;
		logic [31:0] lifetime;
		logic        node_ctrl;
	} cfg_t;

endpackage
`default_nettype wire

### hw/rtl/pdta_mem.sv
`default_nettype none
module pdta_mem #(
	parameter int DEPTH = pdta_pkg::TABLE_ENTRIES_DEF,
	parameter int AW = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire pdta_pkg::ent_t wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output pdta_pkg::ent_t     rd_data
);

	pdta_pkg::ent_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pdta_engine.sv
`default_nettype none
module pdta_engine #(
	parameter int N = pdta_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pdta_pkg::cfg_t cfg,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [47:0] now_ms,
	input  wire logic [31:0] sync_word,
	input  wire logic [31:0] src_ip,
	input  wire logic [63:0] peer_uid,
	input  wire logic [7:0]  peer_priority,
	input  wire logic        peer_is_control_type,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_res,
	output logic [5:0]       slot,
	output logic [63:0]      uid_out,
	output logic [31:0]      ip_out,
	output logic [7:0]       priority_out,
	output logic             best_valid,
	output logic [5:0]       best_slot,
	output logic             last
);

	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam logic [CW-1:0] CNT_END = CW'(N);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_FIND  = 4'd2;
	localparam logic [3:0] S_AGE   = 4'd3;
	localparam logic [3:0] S_BEST  = 4'd4;
	localparam logic [3:0] S_EMIT  = 4'd5;
	localparam logic [3:0] S_EWAIT = 4'd6;
	localparam logic [3:0] S_HOUT  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [N-1:0]  valid_q, retire_q;

	logic          kind_q, ctype_q;
	logic [47:0]   now_q;
	logic [31:0]   sync_q, ip_q;
	logic [63:0]   uid_q;
	logic [7:0]    prio_q;

	logic          match_q, free_q;
	logic [IW-1:0] match_idx_q, free_idx_q;
	logic [2:0]    ev_q;
	logic [IW-1:0] hslot_q;
	logic          best_found_q;
	logic [7:0]    best_prio_q;
	logic [IW-1:0] best_idx_q;

	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	pdta_pkg::ent_t rd_data, wr_data;
	logic          scan_issue, scan_end;
	logic          slot_free, out_ld;
	logic [2:0]    ld_ev;
	logic [5:0]    ld_slot;
	logic [63:0]   ld_uid;
	logic [31:0]   ld_ip;
	logic [7:0]    ld_prio;
	logic          ld_last;
	logic [47:0]   age;

	pdta_mem #(.DEPTH(N), .AW(IW)) u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign in_stall = (state_q != S_IDLE);
	assign slot_free = !out_valid || !out_stall;
	assign scan_issue = (state_q == S_FIND || state_q == S_AGE || state_q == S_BEST)
		&& (cnt_q != CNT_END);
	assign scan_end = (cnt_q == CNT_END) && !rd_v_s1;
	assign age = now_q - rd_data.seen;

	assign wr_data = '{uid: uid_q, ip: ip_q, prio: prio_q, ctype: ctype_q, seen: now_q};
	assign wr_en = (state_q == S_FIND) && scan_end && (match_q || free_q);
	assign wr_addr = match_q ? match_idx_q : free_idx_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		rd_en = 1'b0;
		rd_addr = cnt_q[IW-1:0];
		out_ld = 1'b0;
		ld_ev = pdta_pkg::EV_DONE;
		ld_slot = '0;
		ld_uid = uid_q;
		ld_ip = ip_q;
		ld_prio = prio_q;
		ld_last = 1'b1;
		if (scan_issue) begin
			rd_en = 1'b1;
			cnt_d = cnt_q + CW'(1);
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cnt_d = '0;
				if (kind_q) begin
					state_d = S_AGE;
				end else if (sync_q != cfg.sync) begin
					state_d = S_BEST;
				end else if ((ip_q & cfg.mask) != (cfg.own_ip & cfg.mask)) begin
					state_d = S_BEST;
				end else if (uid_q[15:0] == cfg.ctrl_inst) begin
					state_d = S_FIND;
				end else begin
					state_d = S_BEST;
				end
			end
			S_FIND, S_AGE: begin
				if (scan_end) begin
					cnt_d = '0;
					state_d = S_BEST;
				end
			end
			S_BEST: begin
				if (scan_end) begin
					cnt_d = '0;
					state_d = kind_q ? S_EMIT : S_HOUT;
				end
			end
			S_EMIT: begin
				if (cnt_q == CNT_END) begin
					state_d = S_DONE;
				end else if (retire_q[cnt_q[IW-1:0]]) begin
					rd_en = 1'b1;
					state_d = S_EWAIT;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			S_EWAIT: begin
				if (slot_free) begin
					out_ld = 1'b1;
					ld_ev = pdta_pkg::EV_DOWN;
					ld_slot = 6'(cnt_q[IW-1:0]);
					ld_uid = rd_data.uid;
					ld_ip = rd_data.ip;
					ld_prio = rd_data.prio;
					ld_last = 1'b0;
					cnt_d = cnt_q + CW'(1);
					state_d = S_EMIT;
				end
			end
			S_HOUT: begin
				if (slot_free) begin
					out_ld = 1'b1;
					ld_ev = ev_q;
					ld_slot = (ev_q == pdta_pkg::EV_ADDED || ev_q == pdta_pkg::EV_REFRESH)
						? 6'(hslot_q) : 6'd0;
					state_d = S_IDLE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					out_ld = 1'b1;
					ld_uid = '0;
					ld_ip = '0;
					ld_prio = '0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			valid_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rd_v_s1 <= scan_issue;
			if (out_ld) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			// retire aged entries as their data returns
			if (state_q == S_AGE && rd_v_s1 && valid_q[rd_idx_s1]
					&& age >= {16'd0, cfg.lifetime}) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (state_q == S_IDLE) begin
			kind_q <= kind;
			now_q <= now_ms;
			sync_q <= sync_word;
			ip_q <= src_ip;
			uid_q <= peer_uid;
			prio_q <= peer_priority;
			ctype_q <= peer_is_control_type;
		end
		if (state_q == S_CHK) begin
			match_q <= 1'b0;
			free_q <= 1'b0;
			retire_q <= '0;
			hslot_q <= '0;
			if (sync_q != cfg.sync) begin
				ev_q <= pdta_pkg::EV_BADSYNC;
			end else if ((ip_q & cfg.mask) != (cfg.own_ip & cfg.mask)) begin
				ev_q <= pdta_pkg::EV_OFFNET;
			end else if (uid_q[15:0] == cfg.ctrl_inst) begin
				ev_q <= pdta_pkg::EV_FULL;
			end else if (cfg.node_ctrl) begin
				ev_q <= pdta_pkg::EV_BEACON;
			end else begin
				ev_q <= pdta_pkg::EV_DONE;
			end
		end
		if (state_q == S_FIND && rd_v_s1) begin
			if (!valid_q[rd_idx_s1]) begin
				if (!free_q) begin
					free_q <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end else if (rd_data.uid == uid_q && !match_q) begin
				match_q <= 1'b1;
				match_idx_q <= rd_idx_s1;
			end
		end
		if (state_q == S_FIND && scan_end) begin
			if (match_q) begin
				ev_q <= pdta_pkg::EV_REFRESH;
				hslot_q <= match_idx_q;
			end else if (free_q) begin
				ev_q <= pdta_pkg::EV_ADDED;
				hslot_q <= free_idx_q;
			end
		end
		if (state_q == S_AGE && rd_v_s1 && valid_q[rd_idx_s1]
				&& age >= {16'd0, cfg.lifetime}) begin
			retire_q[rd_idx_s1] <= 1'b1;
		end
		if (state_q != S_BEST) begin
			if (state_d == S_BEST) begin
				best_found_q <= 1'b0;
				best_prio_q <= '0;
				best_idx_q <= '0;
			end
		end else if (rd_v_s1 && valid_q[rd_idx_s1] && rd_data.ctype
				&& (!best_found_q || rd_data.prio > best_prio_q)) begin
			best_found_q <= 1'b1;
			best_prio_q <= rd_data.prio;
			best_idx_q <= rd_idx_s1;
		end
		if (out_ld) begin
			event_res <= ld_ev;
			slot <= ld_slot;
			uid_out <= ld_uid;
			ip_out <= ld_ip;
			priority_out <= ld_prio;
			best_valid <= best_found_q;
			best_slot <= best_found_q ? 6'(best_idx_q) : 6'd0;
			last <= ld_last;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/peer_discovery_table_aging_top.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   kind now_ms sync_word src_ip peer_uid ...
// out      output     out_valid/out_stall event_res slot uid_out ... best_slot last
// cfg      input      cfg_valid/cfg_ready cfg_index cfg_data
// One item at a time; every slot is read through the single table memory read port.
// Controller hello: identity scan, then best scan, then result.
// Other hellos: best scan, then result.
// Sweep: aging scan, best scan, emit scan (one down result per retired entry).
// Reset clears the valid flags at once; no clearing pass.
// A stalled output holds the engine; input is stalled while an item is in work.
`default_nettype none
module peer_discovery_table_aging_top #(
	parameter int TABLE_ENTRIES = pdta_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [47:0] now_ms,
	input  wire logic [31:0] sync_word,
	input  wire logic [31:0] src_ip,
	input  wire logic [63:0] peer_uid,
	input  wire logic [7:0]  peer_priority,
	input  wire logic        peer_is_control_type,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_res,
	output logic [5:0]       slot,
	output logic [63:0]      uid_out,
	output logic [31:0]      ip_out,
	output logic [7:0]       priority_out,
	output logic             best_valid,
	output logic [5:0]       best_slot,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	pdta_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_ip <= 32'd0;
			cfg_q.mask <= 32'hFFFF_FF00;
			cfg_q.sync <= 32'd0;
			cfg_q.ctrl_inst <= 16'd0;
			cfg_q.lifetime <= 32'd10000;
			cfg_q.node_ctrl <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pdta_pkg::REG_OWN_IP:    cfg_q.own_ip <= cfg_data;
				pdta_pkg::REG_MASK:      cfg_q.mask <= cfg_data;
				pdta_pkg::REG_SYNC:      cfg_q.sync <= cfg_data;
				pdta_pkg::REG_CTRL_INST: cfg_q.ctrl_inst <= cfg_data[15:0];
				pdta_pkg::REG_LIFETIME:  cfg_q.lifetime <= cfg_data;
				pdta_pkg::REG_NODE_CTRL: cfg_q.node_ctrl <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pdta_engine #(.N(TABLE_ENTRIES)) u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .now_ms(now_ms),
		.sync_word(sync_word), .src_ip(src_ip), .peer_uid(peer_uid),
		.peer_priority(peer_priority), .peer_is_control_type(peer_is_control_type),
		.out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
		.slot(slot), .uid_out(uid_out), .ip_out(ip_out), .priority_out(priority_out),
		.best_valid(best_valid), .best_slot(best_slot), .last(last)
	);

`ifndef ASSERT_OFF
	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !best_valid |-> best_slot == 6'd0)
		else $error("best_slot set without a controller");
	a_down_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == pdta_pkg::EV_DOWN |-> !last)
		else $error("down result marked last");
	a_other_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != pdta_pkg::EV_DOWN |-> last)
		else $error("final result not marked last");
`endif

endmodule
`default_nettype wire
